>>> rtl/dnsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsr_pkg: shared types and constants for the requantizer
// Channel count, queue sizing, generator stride constants and the item
// record carried from the front end to the back end.
// ----------------------------------------------------------------------------
package dnsr_pkg;

   localparam int CHANNELS    = 2;
   localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [31:0] SEED_RESET = 32'd1;

   // five generator steps r <- (15r) ^ 1 collapse to 15^5*r +/- 47461,
   // plus for even r, minus for odd r
   localparam logic [31:0] GEN_MULT5 = 32'd759375;
   localparam logic [31:0] GEN_OFS5  = 32'd47461;

   localparam logic signed [15:0] PCM_MAX   = 16'sh7FFF;
   localparam logic signed [15:0] PCM_MIN   = 16'sh8000;
   localparam logic [15:0]        COUNT_MAX = 16'hFFFF;

   // clipped output level times 256, for the error update on a clip
   localparam logic signed [33:0] ERR_BASE_HI = 34'sd8388352;
   localparam logic signed [33:0] ERR_BASE_LO = -34'sd8388608;

   typedef struct packed {
      logic [CH_W-1:0]    chan;
      logic signed [31:0] sample;
      logic               last;
      logic [30:0]        a_half;
      logic [30:0]        b_half;
   } item_type;

endpackage

>>> rtl/dnsr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsr_front: input stage
// Accepts a sample, clamps the channel, advances that channel's dither
// generator by five steps and registers the item for the queue.
// ----------------------------------------------------------------------------
module dnsr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic               chan_idx,
   input  logic signed [31:0] sample,
   input  logic               last,
   input  logic               csr_we,
   input  logic [31:0]        csr_data,
   output dnsr_pkg::item_type item,
   output logic               item_valid,
   input  logic               item_ready
);
   import dnsr_pkg::*;

   logic [31:0] gen_ff [CHANNELS];
   logic        valid_ff, valid_in;
   item_type    item_ff, item_in;

   logic            front_ready, accept;
   logic [CH_W-1:0] chan;
   logic [31:0]     gen_old, prod, gen_new;

   assign front_ready = !valid_ff || item_ready;
   assign full        = !front_ready;
   assign accept      = push && front_ready;

   always_comb begin
      if (32'(chan_idx) >= CHANNELS) begin
         chan = CH_W'(CHANNELS - 1);
      end else begin
         chan = CH_W'(chan_idx);
      end
   end

   assign gen_old = gen_ff[chan];
   assign prod    = gen_old * GEN_MULT5;
   assign gen_new = gen_old[0] ? (prod - GEN_OFS5) : (prod + GEN_OFS5);

   always_comb begin
      item_in.chan   = chan;
      item_in.sample = sample;
      item_in.last   = last;
      item_in.a_half = ~gen_old[31:1];
      item_in.b_half = gen_new[31:1];
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (item_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int c = 0; c < CHANNELS; c++) begin
            gen_ff[c] <= SEED_RESET + 32'(c);
         end
      end else begin
         valid_ff <= valid_in;
         if (csr_we) begin
            for (int c = 0; c < CHANNELS; c++) begin
               gen_ff[c] <= csr_data + 32'(c);
            end
         end else if (accept) begin
            gen_ff[chan] <= gen_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item       = item_ff;
   assign item_valid = valid_ff;

endmodule

>>> rtl/dnsr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsr_queue: item queue between front and back end
// Small register queue; lets either side stall without stopping the other.
// ----------------------------------------------------------------------------
module dnsr_queue (
   input  logic               clock,
   input  logic               reset,
   input  dnsr_pkg::item_type in_item,
   input  logic               in_valid,
   output logic               in_ready,
   output dnsr_pkg::item_type out_item,
   output logic               out_valid,
   input  logic               out_ready
);
   import dnsr_pkg::*;

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              wr, rd;

   assign in_ready  = (count_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign wr        = in_valid && in_ready;
   assign rd        = out_valid && out_ready;
   assign out_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr && !rd) begin
         count_in = count_ff + 1'b1;
      end else if (rd && !wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rd) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

>>> rtl/dnsr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsr_back: dither, error feedback, rounding and clipping
// Stage 1 forms the TPDF dither; stage 2 closes the per-channel error
// loop, rounds, clips, counts clips and holds the result beat.
// ----------------------------------------------------------------------------
module dnsr_back (
   input  logic               clock,
   input  logic               reset,
   input  dnsr_pkg::item_type in_item,
   input  logic               in_valid,
   output logic               in_ready,
   output logic               out_valid,
   input  logic               out_ready,
   output logic signed [15:0] pcm_sample,
   output logic               clip_flag,
   output logic [15:0]        clipped_count,
   output logic               block_done
);
   import dnsr_pkg::*;

   // stage 1
   logic               s1_valid_ff;
   logic [CH_W-1:0]    s1_chan_ff;
   logic signed [31:0] s1_sample_ff;
   logic               s1_last_ff;
   logic signed [9:0]  s1_dith_ff, s1_dith_in;   // dither plus rounding half
   logic [31:0]        dsum;

   // stage 2
   logic               rsp_valid_ff;
   logic signed [15:0] pcm_ff, pcm_in;
   logic               clip_ff, clip_in;
   logic [15:0]        cnt_out_ff, cnt_in;
   logic               done_ff;
   logic signed [31:0] err_ff [CHANNELS];
   logic signed [31:0] err_in;
   logic [15:0]        blk_cnt_ff;

   logic               s1_ready, s2_ready, s1_load, s2_load;
   logic signed [31:0] err_cur;
   logic signed [32:0] diff;
   logic signed [33:0] vsum, e_hi, e_lo;
   logic [25:0]        qv;
   logic               ovr, und;
   logic signed [10:0] e_small;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
      logic signed [31:0] r;
      if (x[33] == 1'b0 && x[32:31] != 2'b00) begin
         r = 32'sh7FFFFFFF;
      end else if (x[33] == 1'b1 && x[32:31] != 2'b11) begin
         r = 32'sh80000000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

   assign s2_ready  = !rsp_valid_ff || out_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign in_ready  = s1_ready;
   assign s1_load   = in_valid && s1_ready;
   assign s2_load   = s1_valid_ff && s2_ready;

   // ((a>>1)+(b>>1))>>23 - 256 + 128
   assign dsum       = {1'b0, in_item.a_half} + {1'b0, in_item.b_half};
   assign s1_dith_in = $signed({1'b0, dsum[31:23]}) - 10'sd128;

   assign err_cur = err_ff[s1_chan_ff];
   assign diff    = {s1_sample_ff[31], s1_sample_ff} - {err_cur[31], err_cur};
   assign vsum    = {diff[32], diff} + {{24{s1_dith_ff[9]}}, s1_dith_ff};
   assign qv      = vsum[33:8];
   assign ovr     = !qv[25] && (qv[24:15] != 10'h000);
   assign und     = qv[25] && (qv[24:15] != 10'h3FF);

   // unclipped: new error = dither + half - fraction of v
   assign e_small = {s1_dith_ff[9], s1_dith_ff} - {3'b000, vsum[7:0]};
   assign e_hi    = ERR_BASE_HI - {diff[32], diff};
   assign e_lo    = ERR_BASE_LO - {diff[32], diff};

   always_comb begin
      clip_in = ovr || und;
      if (ovr) begin
         pcm_in = PCM_MAX;
         err_in = sat32(e_hi);
      end else if (und) begin
         pcm_in = PCM_MIN;
         err_in = sat32(e_lo);
      end else begin
         pcm_in = qv[15:0];
         err_in = {{21{e_small[10]}}, e_small};
      end
      cnt_in = blk_cnt_ff + 16'(clip_in && (blk_cnt_ff != COUNT_MAX));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         blk_cnt_ff   <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            err_ff[c] <= '0;
         end
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s2_load) begin
            err_ff[s1_chan_ff] <= err_in;
            blk_cnt_ff         <= s1_last_ff ? 16'd0 : cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_chan_ff   <= in_item.chan;
         s1_sample_ff <= in_item.sample;
         s1_last_ff   <= in_item.last;
         s1_dith_ff   <= s1_dith_in;
      end
      if (s2_load) begin
         pcm_ff     <= pcm_in;
         clip_ff    <= clip_in;
         cnt_out_ff <= cnt_in;
         done_ff    <= s1_last_ff;
      end
   end

   assign out_valid     = rsp_valid_ff;
   assign pcm_sample    = pcm_ff;
   assign clip_flag     = clip_ff;
   assign clipped_count = cnt_out_ff;
   assign block_done    = done_ff;

endmodule

>>> rtl/dithered_noise_shaped_requantizer_unit.sv
`timescale 1ns / 1ps
// Pipeline: a pushed beat passes the front register, queue, dither stage and
// error-feedback stage before it shows on the result ports.
// Throughput: one beat per cycle unless rsp_pop stalls; the per-channel error
// loop closes within back-end stage 2, the generator in a single multiply in front.
// Reset: synchronous; queue and pipeline empty, errors and clip count zero,
// generators loaded with 1 plus channel index.
// ----------------------------------------------------------------------------
// dithered_noise_shaped_requantizer_unit: TPDF-dithered 16-bit requantizer
// Error-feedback requantizer from Q23.8 samples to 16-bit PCM with
// clip flag and per-block clip count.
// ----------------------------------------------------------------------------
module dithered_noise_shaped_requantizer_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_channel_index,
   input  logic signed [31:0] req_sample_value,
   input  logic               req_last_in_block,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [15:0] rsp_pcm_sample,
   output logic               rsp_clip_flag,
   output logic [15:0]        rsp_clipped_count,
   output logic               rsp_block_done,
   input  logic               csr_write_enable,
   input  logic [31:0]        csr_write_data
);
   import dnsr_pkg::*;

   item_type fr_item, q_item;
   logic     fr_valid, fr_ready, q_valid, q_ready, rsp_valid;

   dnsr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .chan_idx   (req_channel_index),
      .sample     (req_sample_value),
      .last       (req_last_in_block),
      .csr_we     (csr_write_enable),
      .csr_data   (csr_write_data),
      .item       (fr_item),
      .item_valid (fr_valid),
      .item_ready (fr_ready)
   );

   dnsr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_item   (fr_item),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .out_item  (q_item),
      .out_valid (q_valid),
      .out_ready (q_ready)
   );

   dnsr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .in_item       (q_item),
      .in_valid      (q_valid),
      .in_ready      (q_ready),
      .out_valid     (rsp_valid),
      .out_ready     (rsp_pop),
      .pcm_sample    (rsp_pcm_sample),
      .clip_flag     (rsp_clip_flag),
      .clipped_count (rsp_clipped_count),
      .block_done    (rsp_block_done)
   );

   assign rsp_empty = !rsp_valid;

endmodule

>>> rtl/dnsr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsr_checker: port-level checks for the requantizer
// Watches the result side for clip consistency and the handshake.
// ----------------------------------------------------------------------------
module dnsr_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_full,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic signed [15:0] rsp_pcm_sample,
   input logic               rsp_clip_flag,
   input logic [15:0]        rsp_clipped_count
);

   // a clipped beat carries a rail value
   a_clip_rail: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_clip_flag) |->
         (rsp_pcm_sample == 16'sh7FFF || rsp_pcm_sample == 16'sh8000))
      else $error("clipped sample not at a rail");

   // a clipped beat is counted
   a_clip_count: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_clip_flag) |-> (rsp_clipped_count != 16'd0))
      else $error("clip not reflected in count");

   // reset drains everything
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("not empty after reset");

   // stalled result beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_pcm_sample) && $stable(rsp_clipped_count)))
      else $error("result changed while stalled");

endmodule

bind dithered_noise_shaped_requantizer_unit dnsr_checker u_dnsr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_full          (req_full),
   .rsp_empty         (rsp_empty),
   .rsp_pop           (rsp_pop),
   .rsp_pcm_sample    (rsp_pcm_sample),
   .rsp_clip_flag     (rsp_clip_flag),
   .rsp_clipped_count (rsp_clipped_count)
);

>>> verif/requant_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// requant_result_checker: result predictor and comparator for the requantizer
// Watches the sample, result and seed ports of the requantizer. For every
// accepted sample it runs its own copy of the dither generators, error
// feedback and clip tally. The expected PCM beat is queued and later compared
// field by field with each popped result beat.
// ----------------------------------------------------------------------------
module requant_result_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_full,
   input  logic               req_channel_index,
   input  logic signed [31:0] req_sample_value,
   input  logic               req_last_in_block,
   input  logic               rsp_empty,
   input  logic               rsp_pop,
   input  logic signed [15:0] rsp_pcm_sample,
   input  logic               rsp_clip_flag,
   input  logic [15:0]        rsp_clipped_count,
   input  logic               rsp_block_done,
   input  logic               csr_write_enable,
   input  logic [31:0]        csr_write_data,
   output int                 fail_count,
   output int                 outstanding
);
   import dnsr_pkg::*;

   localparam longint ERR_HI = 64'sd2147483647;
   localparam longint ERR_LO = -64'sd2147483648;

   typedef struct {
      logic signed [15:0] pcm;
      logic               clip;
      logic [15:0]        count;
      logic               done;
   } pcm_beat_type;

   logic [31:0]        seed_reg;
   logic signed [31:0] err_acc [CHANNELS];
   logic [31:0]        gen_word [CHANNELS];
   logic [15:0]        clip_tally;
   pcm_beat_type       pcm_due_q [$];

   function automatic logic [31:0] gen_advance(logic [31:0] r);
      return (r * 32'd15) ^ 32'd1;
   endfunction

   task automatic reload_generators();
      for (int c = 0; c < CHANNELS; c++) begin
         gen_word[c] = seed_reg + c;
      end
   endtask

   task automatic flag_mismatch(input string what);
      $display("mismatch @%0t: %s", $time, what);
      fail_count++;
   endtask

   // one sample through dither, rounding, clipping and error update
   task automatic requantize_sample(input logic ch_in, input logic signed [31:0] smp,
                                    input logic last, output pcm_beat_type beat);
      int          ch;
      logic [31:0] old_w;
      logic [31:0] inv_w;
      logic [31:0] new_w;
      logic [32:0] half_sum;
      longint      dith;
      longint      v;
      longint      q;
      longint      e;
      logic        clip;
      ch = (ch_in >= CHANNELS) ? CHANNELS - 1 : ch_in;
      old_w = gen_word[ch];
      inv_w = ~old_w;
      new_w = old_w;
      repeat (5) new_w = gen_advance(new_w);
      gen_word[ch] = new_w;
      half_sum = {2'b00, inv_w[31:1]} + {2'b00, new_w[31:1]};
      dith = longint'(half_sum >> 23) - 256;
      v = longint'(smp) - longint'(err_acc[ch]) + dith + 128;
      q = v >>> 8;
      clip = 1'b0;
      if (q > 32767) begin
         q = 32767;
         clip = 1'b1;
      end else if (q < -32768) begin
         q = -32768;
         clip = 1'b1;
      end
      e = longint'(err_acc[ch]) + q * 256 - longint'(smp);
      if (e > ERR_HI) begin
         e = ERR_HI;
      end else if (e < ERR_LO) begin
         e = ERR_LO;
      end
      err_acc[ch] = e[31:0];
      if (clip && clip_tally != COUNT_MAX) begin
         clip_tally++;
      end
      beat.pcm   = q[15:0];
      beat.clip  = clip;
      beat.count = clip_tally;
      beat.done  = last;
      if (last) begin
         clip_tally = '0;
      end
   endtask

   always @(posedge clock) begin : watch
      pcm_beat_type due;
      if (reset) begin
         seed_reg = SEED_RESET;
         for (int c = 0; c < CHANNELS; c++) begin
            err_acc[c] = '0;
         end
         reload_generators();
         clip_tally = '0;
         pcm_due_q.delete();
      end else begin
         if (csr_write_enable) begin
            seed_reg = csr_write_data;
            reload_generators();
         end
         // result side first so a beat can never match a sample of this edge
         if (rsp_pop && !rsp_empty) begin
            if (pcm_due_q.size() == 0) begin
               flag_mismatch("result beat with nothing expected");
            end else begin
               due = pcm_due_q.pop_front();
               if (rsp_pcm_sample !== due.pcm) begin
                  flag_mismatch($sformatf("pcm_sample got %0d want %0d",
                                          rsp_pcm_sample, due.pcm));
               end
               if (rsp_clip_flag !== due.clip) begin
                  flag_mismatch($sformatf("clip_flag got %b want %b",
                                          rsp_clip_flag, due.clip));
               end
               if (rsp_clipped_count !== due.count) begin
                  flag_mismatch($sformatf("clipped_count got %0d want %0d",
                                          rsp_clipped_count, due.count));
               end
               if (rsp_block_done !== due.done) begin
                  flag_mismatch($sformatf("block_done got %b want %b",
                                          rsp_block_done, due.done));
               end
            end
         end
         if (req_push && !req_full) begin
            requantize_sample(req_channel_index, req_sample_value, req_last_in_block, due);
            pcm_due_q.push_back(due);
         end
      end
      outstanding <= pcm_due_q.size();
   end

endmodule

>>> verif/dithered_noise_shaped_requantizer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dithered_noise_shaped_requantizer_unit_test: requantizer testbench top
// Drives directed and random sample beats with random gaps on both sides,
// reprograms the dither seed between phases, runs a clipping burst and
// reports the checker's verdict.
// ----------------------------------------------------------------------------
module dithered_noise_shaped_requantizer_unit_test;

   localparam int CYCLE_LIMIT = 600000;
   localparam int BURST_LEN   = 60;

   localparam logic signed [31:0] S_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] S_MIN = 32'sh80000000;
   localparam logic signed [31:0] S_TOP = 32'sh007FFF00;  // 32767 in Q.8
   localparam logic signed [31:0] S_BOT = 32'shFF800000;  // -32768 in Q.8

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic               req_channel_index = 1'b0;
   logic signed [31:0] req_sample_value = '0;
   logic               req_last_in_block = 1'b0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic signed [15:0] rsp_pcm_sample;
   logic               rsp_clip_flag;
   logic [15:0]        rsp_clipped_count;
   logic               rsp_block_done;
   logic               csr_write_enable = 1'b0;
   logic [31:0]        csr_write_data = '0;

   int fail_count;
   int outstanding;
   int cycle_count = 0;
   bit send_idle = 1'b1;
   bit pop_idle = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   dithered_noise_shaped_requantizer_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_channel_index (req_channel_index),
      .req_sample_value  (req_sample_value),
      .req_last_in_block (req_last_in_block),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_pcm_sample    (rsp_pcm_sample),
      .rsp_clip_flag     (rsp_clip_flag),
      .rsp_clipped_count (rsp_clipped_count),
      .rsp_block_done    (rsp_block_done),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   requant_result_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_channel_index (req_channel_index),
      .req_sample_value  (req_sample_value),
      .req_last_in_block (req_last_in_block),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_pcm_sample    (rsp_pcm_sample),
      .rsp_clip_flag     (rsp_clip_flag),
      .rsp_clipped_count (rsp_clipped_count),
      .rsp_block_done    (rsp_block_done),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .fail_count        (fail_count),
      .outstanding       (outstanding)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // result side: random stall before each beat, then hold pop until taken
   initial begin : pop_side
      int gap;
      forever begin
         gap = pop_idle ? $urandom_range(0, 17) : 0;
         if (gap != 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty !== 1'b0);
      end
   end

   task automatic send_sample(input logic ch, input logic signed [31:0] smp, input logic last);
      int gap;
      gap = send_idle ? $urandom_range(0, 17) : 0;
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push          <= 1'b1;
      req_channel_index <= ch;
      req_sample_value  <= smp;
      req_last_in_block <= last;
      do @(posedge clock); while (req_full !== 1'b0);
   endtask

   task automatic wait_results_drained();
      req_push <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic load_dither_seed(input logic [31:0] seed);
      csr_write_enable <= 1'b1;
      csr_write_data   <= seed;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic signed [31:0] pick_sample();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return int'($urandom_range(0, 2047)) - 1024;
         2: return S_TOP + (int'($urandom_range(0, 1023)) - 512);
         3: return S_BOT + (int'($urandom_range(0, 1023)) - 512);
         4: return $urandom_range(0, 1) ? S_MAX : S_MIN;
         default: return int'($urandom) >>> $urandom_range(8, 24);
      endcase
   endfunction

   task automatic run_random(input int n);
      for (int i = 0; i < n; i++) begin
         send_sample(1'($urandom_range(0, 1)), pick_sample(), $urandom_range(0, 7) == 0);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero, clip edges, error saturation both ways, rounding edge
      send_sample(1'b0, 32'sd0, 1'b0);
      send_sample(1'b1, 32'sd0, 1'b0);
      send_sample(1'b0, S_MAX, 1'b0);
      send_sample(1'b0, S_MIN, 1'b0);
      send_sample(1'b0, S_MIN, 1'b0);
      send_sample(1'b0, S_MIN, 1'b0);
      send_sample(1'b1, S_TOP, 1'b0);
      send_sample(1'b1, S_BOT, 1'b0);
      send_sample(1'b1, 32'sh00800000, 1'b0);
      send_sample(1'b0, 32'sh00000080, 1'b1);
      send_sample(1'b1, -32'sd129, 1'b0);
      send_sample(1'b0, S_MAX, 1'b0);
      send_sample(1'b0, S_MAX, 1'b0);
      send_sample(1'b0, S_MAX, 1'b0);
      send_sample(1'b1, 32'sd1, 1'b1);
      send_sample(1'b0, -32'sd1, 1'b0);
      send_sample(1'b1, 32'sh55555555, 1'b0);
      send_sample(1'b0, 32'shAAAAAAAA, 1'b1);
      send_sample(1'b1, S_BOT - 32'sd1, 1'b1);

      wait_results_drained();
      load_dither_seed(32'h00000000);
      run_random(150);

      // no idling on either side for this stretch
      wait_results_drained();
      load_dither_seed(32'hFFFFFFFF);
      send_idle = 1'b0;
      pop_idle  = 1'b0;
      run_random(150);

      // clipping burst of full-scale positive samples, one block
      wait_results_drained();
      load_dither_seed($urandom);
      for (int i = 0; i < BURST_LEN; i++) begin
         send_sample(1'($urandom_range(0, 1)), S_MAX, i == BURST_LEN - 1);
      end

      wait_results_drained();
      load_dither_seed($urandom);
      send_idle = 1'b1;
      pop_idle  = 1'b1;
      run_random(120);

      wait_results_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
